### design/fla_pkg.sv
package fla_pkg;

   // Width of the address and size fields on the ports
   localparam int FIELD_W = 16;
   // Width of the free-entry count on the response
   localparam int COUNT_OUT_W = 5;
   // Pool size after reset
   localparam logic [FIELD_W-1:0] POOL_RESET = 16'd4096;

   // Capacity of the free list
   localparam int MAX_FREE_BLOCKS = 16;
   // Width of stored region starts and lengths
   localparam int ADDR_WIDTH = 16;

   // Configuration register indexes
   localparam logic CSR_FIT  = 1'b0;
   localparam logic CSR_POOL = 1'b1;

   // Request kinds
   localparam logic OP_ALLOC = 1'b0;
   localparam logic OP_FREE  = 1'b1;

   typedef enum logic [1:0] {
      FIT_BEST  = 2'd0,
      FIT_WORST = 2'd1,
      FIT_FIRST = 2'd2,
      FIT_NEXT  = 2'd3
   } fit_type;

   typedef enum logic [1:0] {
      ST_ALLOC = 2'd0,
      ST_NOFIT = 2'd1,
      ST_FREED = 2'd2,
      ST_FULL  = 2'd3
   } resp_code_type;

   // Commands from the controller to the datapath
   typedef struct packed {
      logic init_wr;       // rebuild the list as one region
      logic accept;        // latch the incoming request
      logic free_commit;   // append a freed region
      logic alloc_reject;  // answer no block fits
      logic mod_start;     // start reducing the next-fit position
      logic mod_step;      // one remainder step
      logic scan_start;    // set up the search
      logic scan_rd;       // read one entry for the search
      logic take;          // allocate from the chosen entry
      logic shift_rd;      // move one entry down
      logic rsp_load;      // load the response register
   } ctrl_cmd_type;

   // Status from the datapath to the controller
   typedef struct packed {
      logic pool_wr;
      logic is_free;
      logic alloc_trivial;
      logic use_mod;
      logic mod_done;
      logic scan_last;
      logic found;
      logic exact;
      logic tail;
      logic shift_last;
      logic rsp_free;
   } ctrl_status_type;

endpackage

### design/fla_ctrl.sv
module fla_ctrl
   import fla_pkg::*;
(
   input  logic            clock,
   input  logic            reset,
   input  logic            req_tvalid,
   output logic            req_tready,
   input  ctrl_status_type st,
   output ctrl_cmd_type    cmd
);

   typedef enum logic [9:0] {
      S_INIT   = 10'b0000000001,
      S_IDLE   = 10'b0000000010,
      S_CHECK  = 10'b0000000100,
      S_MOD    = 10'b0000001000,
      S_SETUP  = 10'b0000010000,
      S_SCAN   = 10'b0000100000,
      S_LAST   = 10'b0001000000,
      S_DECIDE = 10'b0010000000,
      S_SHIFT  = 10'b0100000000,
      S_DONE   = 10'b1000000000
   } state_type;

   state_type state_ff;
   state_type state_in;

   assign req_tready = (state_ff == S_IDLE) && !st.pool_wr;

   // Sequence one request at a time
   always_comb begin
      cmd      = '0;
      state_in = state_ff;
      case (state_ff)
         S_INIT: begin
            cmd.init_wr = 1'b1;
            if (!st.pool_wr) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            if (st.pool_wr) begin
               state_in = S_INIT;
            end else if (req_tvalid) begin
               cmd.accept = 1'b1;
               state_in   = S_CHECK;
            end
         end
         S_CHECK: begin
            if (st.is_free) begin
               cmd.free_commit = 1'b1;
               state_in        = S_DONE;
            end else if (st.alloc_trivial) begin
               cmd.alloc_reject = 1'b1;
               state_in         = S_DONE;
            end else if (st.use_mod) begin
               cmd.mod_start = 1'b1;
               state_in      = S_MOD;
            end else begin
               state_in = S_SETUP;
            end
         end
         S_MOD: begin
            cmd.mod_step = 1'b1;
            if (st.mod_done) begin
               state_in = S_SETUP;
            end
         end
         S_SETUP: begin
            cmd.scan_start = 1'b1;
            state_in       = S_SCAN;
         end
         S_SCAN: begin
            cmd.scan_rd = 1'b1;
            if (st.scan_last) begin
               state_in = S_LAST;
            end
         end
         S_LAST: begin
            state_in = S_DECIDE;
         end
         S_DECIDE: begin
            if (!st.found) begin
               cmd.alloc_reject = 1'b1;
               state_in         = S_DONE;
            end else begin
               cmd.take = 1'b1;
               if (st.exact && !st.tail) begin
                  state_in = S_SHIFT;
               end else begin
                  state_in = S_DONE;
               end
            end
         end
         S_SHIFT: begin
            cmd.shift_rd = 1'b1;
            if (st.shift_last) begin
               state_in = S_DONE;
            end
         end
         S_DONE: begin
            if (st.rsp_free) begin
               cmd.rsp_load = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_INIT;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

### design/fla_dpath.sv
module fla_dpath
   import fla_pkg::*;
(
   input  logic            clock,
   input  logic            reset,
   input  logic [31:0]     req_tdata,
   input  logic            req_tuser,
   input  logic            csr_wen,
   input  logic            csr_addr,
   input  logic [15:0]     csr_wdata,
   output logic            rsp_tvalid,
   input  logic            rsp_tready,
   output logic [23:0]     rsp_tdata,
   output logic [1:0]      rsp_tuser,
   input  ctrl_cmd_type    cmd,
   output ctrl_status_type st
);

   localparam int AW     = ADDR_WIDTH;
   localparam int IDX_W  = $clog2(MAX_FREE_BLOCKS);
   localparam int CNT_W  = $clog2(MAX_FREE_BLOCKS + 1);
   localparam int MCNT_W = $clog2(IDX_W + 1);

   typedef struct packed {
      logic [AW-1:0] start;
      logic [AW-1:0] len;
   } entry_type;

   // Free list storage
   entry_type mem_ram [MAX_FREE_BLOCKS];
   entry_type rd_data_ff;
   logic             mem_we;
   logic [IDX_W-1:0] mem_waddr;
   entry_type        mem_wdata;
   logic             mem_re;
   logic [IDX_W-1:0] mem_raddr;

   // Configuration and list state
   fit_type            fit_ff,   fit_in;
   logic [FIELD_W-1:0] pool_ff,  pool_in;
   logic [CNT_W-1:0]   count_ff, count_in;
   logic [IDX_W-1:0]   pos_ff,   pos_in;

   // Latched request
   logic          op_ff,    op_in;
   logic [AW-1:0] start_ff, start_in;
   logic [AW-1:0] size_ff,  size_in;

   // Remainder unit for the next-fit start
   logic [CNT_W-1:0]  r_ff,    r_in;
   logic [IDX_W-1:0]  sh_ff,   sh_in;
   logic [MCNT_W-1:0] mcnt_ff, mcnt_in;
   logic [CNT_W:0]    trial;

   // Search
   logic [IDX_W-1:0] addr_ff,     addr_in;
   logic [CNT_W-1:0] scnt_ff,     scnt_in;
   logic             rdv_ff,      rdv_in;
   logic [IDX_W-1:0] rd_idx_ff,   rd_idx_in;
   logic             found_ff,    found_in;
   logic [IDX_W-1:0] ch_idx_ff,   ch_idx_in;
   logic [AW-1:0]    ch_start_ff, ch_start_in;
   logic [AW-1:0]    ch_len_ff,   ch_len_in;
   logic             better;

   // Shift-down
   logic [IDX_W-1:0] k_ff,     k_in;
   logic             wpend_ff, wpend_in;
   logic [IDX_W-1:0] waddr_ff, waddr_in;

   // Result and response
   resp_code_type          res_code_ff,  res_code_in;
   logic [AW-1:0]          res_addr_ff,  res_addr_in;
   logic                   rsp_valid_ff, rsp_valid_in;
   resp_code_type          rsp_code_ff,  rsp_code_in;
   logic [FIELD_W-1:0]     rsp_addr_ff,  rsp_addr_in;
   logic [COUNT_OUT_W-1:0] rsp_cnt_ff,   rsp_cnt_in;

   assign trial = {r_ff, sh_ff[IDX_W-1]};

   // Pick the candidate under the current fit rule
   always_comb begin
      better = 1'b0;
      if (rdv_ff && (rd_data_ff.len >= size_ff)) begin
         if (!found_ff) begin
            better = 1'b1;
         end else begin
            case (fit_ff)
               FIT_BEST:  better = (rd_data_ff.len < ch_len_ff);
               FIT_WORST: better = (rd_data_ff.len > ch_len_ff);
               default:   better = 1'b0;
            endcase
         end
      end
   end

   always_comb begin
      fit_in       = fit_ff;
      pool_in      = pool_ff;
      count_in     = count_ff;
      pos_in       = pos_ff;
      op_in        = op_ff;
      start_in     = start_ff;
      size_in      = size_ff;
      r_in         = r_ff;
      sh_in        = sh_ff;
      mcnt_in      = mcnt_ff;
      addr_in      = addr_ff;
      scnt_in      = scnt_ff;
      rdv_in       = cmd.scan_rd;
      rd_idx_in    = addr_ff;
      found_in     = found_ff;
      ch_idx_in    = ch_idx_ff;
      ch_start_in  = ch_start_ff;
      ch_len_in    = ch_len_ff;
      k_in         = k_ff;
      wpend_in     = 1'b0;
      waddr_in     = waddr_ff;
      res_code_in  = res_code_ff;
      res_addr_in  = res_addr_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_code_in  = rsp_code_ff;
      rsp_addr_in  = rsp_addr_ff;
      rsp_cnt_in   = rsp_cnt_ff;
      mem_we       = 1'b0;
      mem_waddr    = '0;
      mem_wdata    = '0;
      mem_re       = 1'b0;
      mem_raddr    = '0;

      // Take configuration writes
      if (csr_wen) begin
         if (csr_addr == CSR_FIT) begin
            fit_in = fit_type'(csr_wdata[1:0]);
         end else begin
            pool_in = csr_wdata;
         end
      end

      // Rebuild the list as one region at zero
      if (cmd.init_wr) begin
         mem_we          = 1'b1;
         mem_waddr       = '0;
         mem_wdata.start = '0;
         mem_wdata.len   = AW'(pool_ff);
         count_in        = (AW'(pool_ff) != '0) ? CNT_W'(1) : '0;
         pos_in          = '0;
      end

      // Latch the request
      if (cmd.accept) begin
         op_in    = req_tuser;
         start_in = AW'(req_tdata[15:0]);
         size_in  = AW'(req_tdata[31:16]);
      end

      // Append a freed region unless empty or the list is full
      if (cmd.free_commit) begin
         res_addr_in = '0;
         res_code_in = ST_FREED;
         if (size_ff != '0) begin
            if (count_ff == CNT_W'(MAX_FREE_BLOCKS)) begin
               res_code_in = ST_FULL;
            end else begin
               mem_we          = 1'b1;
               mem_waddr       = count_ff[IDX_W-1:0];
               mem_wdata.start = start_ff;
               mem_wdata.len   = size_ff;
               count_in        = count_ff + CNT_W'(1);
            end
         end
      end

      if (cmd.alloc_reject) begin
         res_code_in = ST_NOFIT;
         res_addr_in = '0;
      end

      // Reduce the next-fit position modulo the count, one bit a cycle
      if (cmd.mod_start) begin
         sh_in   = pos_ff;
         r_in    = '0;
         mcnt_in = MCNT_W'(IDX_W);
      end
      if (cmd.mod_step) begin
         if (trial >= {1'b0, count_ff}) begin
            r_in = CNT_W'(trial - {1'b0, count_ff});
         end else begin
            r_in = CNT_W'(trial);
         end
         sh_in   = sh_ff << 1;
         mcnt_in = mcnt_ff - MCNT_W'(1);
      end

      // Walk the list, circularly from the start point
      if (cmd.scan_start) begin
         addr_in  = (fit_ff == FIT_NEXT) ? r_ff[IDX_W-1:0] : '0;
         scnt_in  = '0;
         found_in = 1'b0;
      end
      if (cmd.scan_rd) begin
         mem_re    = 1'b1;
         mem_raddr = addr_ff;
         if (CNT_W'(addr_ff) + CNT_W'(1) == count_ff) begin
            addr_in = '0;
         end else begin
            addr_in = addr_ff + IDX_W'(1);
         end
         scnt_in = scnt_ff + CNT_W'(1);
      end
      if (better) begin
         found_in    = 1'b1;
         ch_idx_in   = rd_idx_ff;
         ch_start_in = rd_data_ff.start;
         ch_len_in   = rd_data_ff.len;
      end

      // Carve from the chosen entry, or drop it when used up
      if (cmd.take) begin
         res_code_in = ST_ALLOC;
         res_addr_in = ch_start_ff;
         if (fit_ff == FIT_NEXT) begin
            if (CNT_W'(ch_idx_ff) + CNT_W'(1) == count_ff) begin
               pos_in = '0;
            end else begin
               pos_in = ch_idx_ff + IDX_W'(1);
            end
         end
         if (ch_len_ff == size_ff) begin
            count_in = count_ff - CNT_W'(1);
            k_in     = ch_idx_ff;
         end else begin
            mem_we          = 1'b1;
            mem_waddr       = ch_idx_ff;
            mem_wdata.start = ch_start_ff + size_ff;
            mem_wdata.len   = ch_len_ff - size_ff;
         end
      end

      // Move later entries down: read one ahead, write it in the following cycle
      if (cmd.shift_rd) begin
         mem_re    = 1'b1;
         mem_raddr = k_ff + IDX_W'(1);
         wpend_in  = 1'b1;
         waddr_in  = k_ff;
         k_in      = k_ff + IDX_W'(1);
      end
      if (wpend_ff) begin
         mem_we    = 1'b1;
         mem_waddr = waddr_ff;
         mem_wdata = rd_data_ff;
      end

      // Hold the response until taken
      if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
      if (cmd.rsp_load) begin
         rsp_valid_in = 1'b1;
         rsp_code_in  = res_code_ff;
         rsp_addr_in  = FIELD_W'(res_addr_ff);
         rsp_cnt_in   = COUNT_OUT_W'(count_ff);
      end
   end

   // Status toward the controller
   always_comb begin
      st.pool_wr       = csr_wen && (csr_addr == CSR_POOL);
      st.is_free       = (op_ff == OP_FREE);
      st.alloc_trivial = (size_ff == '0) || (count_ff == '0);
      st.use_mod       = (fit_ff == FIT_NEXT);
      st.mod_done      = (mcnt_ff == MCNT_W'(1));
      st.scan_last     = (scnt_ff + CNT_W'(1) == count_ff);
      st.found         = found_ff;
      st.exact         = (ch_len_ff == size_ff);
      st.tail          = (CNT_W'(ch_idx_ff) + CNT_W'(1) == count_ff);
      st.shift_last    = (CNT_W'(k_ff) + CNT_W'(1) == count_ff);
      st.rsp_free      = !rsp_valid_ff || rsp_tready;
   end

   // List memory: one write and one registered read per cycle
   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem_ram[mem_waddr] <= mem_wdata;
      end
      if (mem_re) begin
         rd_data_ff <= mem_ram[mem_raddr];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fit_ff       <= FIT_BEST;
         pool_ff      <= POOL_RESET;
         count_ff     <= '0;
         pos_ff       <= '0;
         rdv_ff       <= 1'b0;
         found_ff     <= 1'b0;
         wpend_ff     <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         fit_ff       <= fit_in;
         pool_ff      <= pool_in;
         count_ff     <= count_in;
         pos_ff       <= pos_in;
         rdv_ff       <= rdv_in;
         found_ff     <= found_in;
         wpend_ff     <= wpend_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      op_ff       <= op_in;
      start_ff    <= start_in;
      size_ff     <= size_in;
      r_ff        <= r_in;
      sh_ff       <= sh_in;
      mcnt_ff     <= mcnt_in;
      addr_ff     <= addr_in;
      scnt_ff     <= scnt_in;
      rd_idx_ff   <= rd_idx_in;
      ch_idx_ff   <= ch_idx_in;
      ch_start_ff <= ch_start_in;
      ch_len_ff   <= ch_len_in;
      k_ff        <= k_in;
      waddr_ff    <= waddr_in;
      res_code_ff <= res_code_in;
      res_addr_ff <= res_addr_in;
      rsp_code_ff <= rsp_code_in;
      rsp_addr_ff <= rsp_addr_in;
      rsp_cnt_ff  <= rsp_cnt_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser  = rsp_code_ff;
   assign rsp_tdata  = {3'b000, rsp_cnt_ff, rsp_addr_ff};

endmodule

### design/free_list_fit_allocator.sv
// Free-list allocator: keeps up to MAX_FREE_BLOCKS free regions and answers
// each request with exactly one response. An allocate (req_tuser 0) searches
// the list by the fit rule in register 0 (best, worst, first or next fit) and
// carves the region from the front of the chosen entry; a free (req_tuser 1)
// appends the region as given, without merging, unless it is empty or the
// list is full. Writing register 1 while idle rebuilds the list as one region
// of pool_size units at zero, as happens right after reset, before the block
// takes a request; req_tready stays low in the cycle of that write.
// Requests are handled one at a time through a list memory with one read and
// one write port, one entry read per cycle. A free is answered without a
// search. An allocate reads all N list entries, after reducing the start
// position modulo N under next fit, and then moves later entries down when
// an entry is used up exactly. A finished response waits in an output
// register while the block goes back to take the next request.
module free_list_fit_allocator
   import fla_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [31:0] req_tdata,   // block_start[15:0], block_size[31:16]
   input  logic        req_tuser,   // operation
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [23:0] rsp_tdata,   // address[15:0], free_blocks[20:16], zero fill
   output logic [1:0]  rsp_tuser,   // status
   input  logic        csr_wen,
   input  logic        csr_addr,
   input  logic [15:0] csr_wdata
);

   ctrl_cmd_type    cmd;
   ctrl_status_type st;

   fla_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .st         (st),
      .cmd        (cmd)
   );

   fla_dpath u_dpath (
      .clock      (clock),
      .reset      (reset),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .csr_wen    (csr_wen),
      .csr_addr   (csr_addr),
      .csr_wdata  (csr_wdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .cmd        (cmd),
      .st         (st)
   );

endmodule

### design/fla_chk.sv
module fla_chk
   import fla_pkg::*;
(
   input logic        clock,
   input logic        reset,
   input logic        req_tvalid,
   input logic        req_tready,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [23:0] rsp_tdata,
   input logic [1:0]  rsp_tuser
);

   // Hold a stalled response
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser))
      else $error("response changed while stalled");

   // Take one request at a time
   assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !req_tready)
      else $error("request taken while one is in work");

   // Report address zero for anything but a granted allocation
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && (rsp_tuser != ST_ALLOC) |-> rsp_tdata[15:0] == 16'd0)
      else $error("address set on a response that allocated nothing");

   // Report a full list only at capacity
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && (rsp_tuser == ST_FULL) |-> rsp_tdata[20:16] == 5'(MAX_FREE_BLOCKS))
      else $error("list full reported below capacity");

endmodule

bind free_list_fit_allocator fla_chk u_fla_chk (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tuser  (rsp_tuser)
);
